// File: src/rrs_pkg.sv
// rrs_pkg: shared types, constants and helpers of the round-robin scheduler
// no dependencies; imported by every module under src
package rrs_pkg;

    // queue geometry and field widths
    localparam int QUEUE_DEPTH = 16;
    localparam int BURST_W     = 8;
    localparam int ID_W        = 4;
    localparam int Q_W         = 8;
    localparam int IN_BURST_W  = 8;
    localparam int QA_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DEC_W       = (BURST_W > Q_W) ? BURST_W : Q_W;

    localparam logic [Q_W-1:0] QUANTUM_RESET = Q_W'(10);

    // input function codes
    localparam logic FUNC_ADMIT = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef logic [BURST_W-1:0] burst_t;
    typedef logic [DEC_W-1:0]   dec_t;
    typedef logic [Q_W-1:0]     quantum_t;
    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [QA_W-1:0]    qaddr_t;

    // one task record
    typedef struct packed {
        logic [ID_W-1:0] id;
        burst_t          cpu;
        burst_t          io;
        burst_t          rem_cpu;
        burst_t          rem_io;
    } rec_t;

    // queue commands from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
        logic wr_head;
    } q_cmd_t;

    // queue status back to the sequencer
    typedef struct packed {
        logic   full;
        logic   empty;
        count_t fill;
    } q_stat_t;

    // keep the low burst bits of an admitted length
    function automatic burst_t to_burst(input logic [IN_BURST_W-1:0] v);
        logic [IN_BURST_W+BURST_W-1:0] w;
        begin
            w = {{BURST_W{1'b0}}, v};
            return w[BURST_W-1:0];
        end
    endfunction

endpackage

// File: src/rrs_dec_unit.sv
// rrs_dec_unit: shared saturating decrementer for quantum and burst countdowns
// depends on rrs_pkg
module rrs_dec_unit (
    input  rrs_pkg::dec_t operand,
    output rrs_pkg::dec_t result,
    output logic          is_zero
);
    import rrs_pkg::*;

    // count down, stick at zero
    assign result  = (operand == '0) ? '0 : operand - dec_t'(1);
    assign is_zero = (result == '0);

endmodule

// File: src/rrs_task_queue.sv
// rrs_task_queue: circular task queue with registered head read
// depends on rrs_pkg; holds its record store in an internal array
module rrs_task_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  rrs_pkg::q_cmd_t  cmd,
    input  rrs_pkg::rec_t    wdata,
    output rrs_pkg::rec_t    head_rec,
    output rrs_pkg::q_stat_t stat
);
    import rrs_pkg::*;

    localparam int SUM_W = CNT_W + 1;

    rec_t   mem [QUEUE_DEPTH];
    rec_t   rd_reg;
    qaddr_t head_reg, head_next;
    count_t fill_reg, fill_next;
    logic [SUM_W-1:0] tail_sum;
    logic [SUM_W-1:0] tail_wrap;
    qaddr_t tail;

    // tail slot, head plus fill modulo depth
    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(fill_reg);
    assign tail_wrap = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? tail_sum - SUM_W'(QUEUE_DEPTH)
                                                         : tail_sum;
    assign tail      = tail_wrap[QA_W-1:0];

    // pointer and count update
    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (cmd.pop)
        begin
            head_next = (head_reg == qaddr_t'(QUEUE_DEPTH - 1)) ? '0 : head_reg + qaddr_t'(1);
        end
        if (cmd.push && !cmd.pop)
        begin
            fill_next = fill_reg + count_t'(1);
        end
        else if (cmd.pop && !cmd.push)
        begin
            fill_next = fill_reg - count_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    // record store, one write and one registered head read a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[tail] <= wdata;
        end
        else if (cmd.wr_head)
        begin
            mem[head_reg] <= wdata;
        end
        rd_reg <= mem[head_reg];
    end

    assign head_rec   = rd_reg;
    assign stat.fill  = fill_reg;
    assign stat.full  = (fill_reg == count_t'(QUEUE_DEPTH));
    assign stat.empty = (fill_reg == '0);

endmodule

// File: src/round_robin_scheduler_io_wait.sv
// Round-robin scheduler with a run queue and an I/O wait queue, one result per input beat.
// An admit queues the task unless the run queue is full. A tick visits every waiter, then
// rotates the run queue if due and charges its head: each queue is read only at its head
// through a registered port, so every head visit passes a read state and an update state,
// and all countdowns go through one shared saturating decrementer. Input is taken only
// while no result is pending. Queue stores are not cleared after reset; only slots that
// hold a task are ever read. The quantum register is written through cfg_we/cfg_data.
// depends on rrs_pkg, rrs_dec_unit, rrs_task_queue
module round_robin_scheduler_io_wait (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        func,
    input  logic [rrs_pkg::ID_W-1:0]    task_id,
    input  logic [7:0]                  cpu_burst_len,
    input  logic [7:0]                  io_burst_len,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rrs_pkg::ID_W-1:0]    running_id,
    output logic                        running_valid,
    output logic [rrs_pkg::Q_W-1:0]     quantum_left,
    output logic [rrs_pkg::CNT_W-1:0]   run_count,
    output logic [rrs_pkg::CNT_W-1:0]   wait_count,
    output logic                        admit_dropped,
    input  logic                        cfg_we,
    input  logic [rrs_pkg::Q_W-1:0]     cfg_data
);
    import rrs_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_WAIT_RD   = 7'b0000010,
        ST_WAIT_PROC = 7'b0000100,
        ST_ROT_RD    = 7'b0001000,
        ST_ROT_PROC  = 7'b0010000,
        ST_HEAD_RD   = 7'b0100000,
        ST_HEAD_PROC = 7'b1000000
    } state_t;

    state_t   state_reg, state_next;
    quantum_t tq_reg;
    quantum_t quantum_reg, quantum_next;
    count_t   wait_left_reg, wait_left_next;
    logic     tick_reg, tick_next;
    logic     dropped_reg, dropped_next;
    logic     out_valid_reg, out_valid_next;
    logic [ID_W-1:0] out_id_reg, out_id_next;
    logic     out_rv_reg, out_rv_next;
    quantum_t out_q_reg, out_q_next;
    count_t   out_run_reg, out_run_next;
    count_t   out_wait_reg, out_wait_next;
    logic     out_drop_reg, out_drop_next;

    q_cmd_t   run_cmd, wait_cmd;
    rec_t     run_wdata, wait_wdata;
    rec_t     run_head, wait_head;
    q_stat_t  run_stat, wait_stat;
    rec_t     rec_in, rec_io, rec_reload;

    dec_t     dec_op, dec_res;
    logic     dec_zero;
    logic     rotate;

    rrs_task_queue u_run_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (run_cmd),
        .wdata    (run_wdata),
        .head_rec (run_head),
        .stat     (run_stat)
    );

    rrs_task_queue u_wait_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (wait_cmd),
        .wdata    (wait_wdata),
        .head_rec (wait_head),
        .stat     (wait_stat)
    );

    rrs_dec_unit u_dec (
        .operand (dec_op),
        .result  (dec_res),
        .is_zero (dec_zero)
    );

    assign in_ready = (state_reg == ST_IDLE) && !out_valid_reg;

    // admitted record
    always_comb
    begin
        rec_in.id      = task_id;
        rec_in.cpu     = to_burst(cpu_burst_len);
        rec_in.io      = to_burst(io_burst_len);
        rec_in.rem_cpu = to_burst(cpu_burst_len);
        rec_in.rem_io  = to_burst(io_burst_len);
    end

    // waiter records after one tick of i/o
    always_comb
    begin
        rec_io            = wait_head;
        rec_io.rem_io     = burst_t'(dec_res);
        rec_reload        = wait_head;
        rec_reload.rem_cpu = wait_head.cpu;
        rec_reload.rem_io  = wait_head.io;
    end

    assign rotate = (quantum_reg == '0) || (!run_stat.empty && run_head.rem_cpu == '0);

    // decrementer operand select
    always_comb
    begin
        priority if (state_reg == ST_WAIT_PROC)
        begin
            dec_op = dec_t'(wait_head.rem_io);
        end
        else if (state_reg == ST_HEAD_PROC)
        begin
            dec_op = dec_t'(run_head.rem_cpu);
        end
        else
        begin
            dec_op = dec_t'(quantum_reg);
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        quantum_next   = quantum_reg;
        wait_left_next = wait_left_reg;
        tick_next      = tick_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_id_next    = out_id_reg;
        out_rv_next    = out_rv_reg;
        out_q_next     = out_q_reg;
        out_run_next   = out_run_reg;
        out_wait_next  = out_wait_reg;
        out_drop_next  = out_drop_reg;
        run_cmd        = '0;
        wait_cmd       = '0;
        run_wdata      = run_head;
        wait_wdata     = wait_head;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    tick_next    = (func == FUNC_TICK);
                    dropped_next = (func == FUNC_ADMIT) && run_stat.full;
                    if (func == FUNC_TICK)
                    begin
                        quantum_next   = quantum_t'(dec_res);
                        wait_left_next = wait_stat.fill;
                        state_next     = wait_stat.empty ? ST_ROT_RD : ST_WAIT_RD;
                    end
                    else
                    begin
                        run_cmd.push = !run_stat.full;
                        run_wdata    = rec_in;
                        state_next   = ST_HEAD_RD;
                    end
                end
            end
            ST_WAIT_RD:
            begin
                state_next = ST_WAIT_PROC;
            end
            ST_WAIT_PROC:
            begin
                wait_cmd.pop = 1'b1;
                if (dec_zero && !run_stat.full)
                begin
                    run_cmd.push = 1'b1;
                    run_wdata    = rec_reload;
                end
                else
                begin
                    wait_cmd.push = 1'b1;
                    wait_wdata    = rec_io;
                end
                wait_left_next = wait_left_reg - count_t'(1);
                state_next     = (wait_left_reg == count_t'(1)) ? ST_ROT_RD : ST_WAIT_RD;
            end
            ST_ROT_RD:
            begin
                state_next = ST_ROT_PROC;
            end
            ST_ROT_PROC:
            begin
                if (rotate)
                begin
                    if (!run_stat.empty)
                    begin
                        run_cmd.pop = 1'b1;
                        if (run_head.rem_cpu != '0 || wait_stat.full)
                        begin
                            run_cmd.push = 1'b1;
                        end
                        else
                        begin
                            wait_cmd.push = 1'b1;
                            wait_wdata    = run_head;
                        end
                    end
                    quantum_next = tq_reg;
                end
                state_next = ST_HEAD_RD;
            end
            ST_HEAD_RD:
            begin
                state_next = ST_HEAD_PROC;
            end
            ST_HEAD_PROC:
            begin
                // on a tick, charge it to a non-empty head; always publish the result beat
                if (tick_reg && !run_stat.empty)
                begin
                    run_cmd.wr_head   = 1'b1;
                    run_wdata.rem_cpu = burst_t'(dec_res);
                end
                out_valid_next = 1'b1;
                out_id_next    = run_stat.empty ? '0 : run_head.id;
                out_rv_next    = !run_stat.empty;
                out_q_next     = quantum_reg;
                out_run_next   = run_stat.fill;
                out_wait_next  = wait_stat.fill;
                out_drop_next  = dropped_reg;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tq_reg        <= QUANTUM_RESET;
            quantum_reg   <= QUANTUM_RESET;
            wait_left_reg <= '0;
            tick_reg      <= 1'b0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            quantum_reg   <= quantum_next;
            wait_left_reg <= wait_left_next;
            tick_reg      <= tick_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                tq_reg <= cfg_data;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_id_reg   <= out_id_next;
        out_rv_reg   <= out_rv_next;
        out_q_reg    <= out_q_next;
        out_run_reg  <= out_run_next;
        out_wait_reg <= out_wait_next;
        out_drop_reg <= out_drop_next;
    end

    assign out_valid     = out_valid_reg;
    assign running_id    = out_id_reg;
    assign running_valid = out_rv_reg;
    assign quantum_left  = out_q_reg;
    assign run_count     = out_run_reg;
    assign wait_count    = out_wait_reg;
    assign admit_dropped = out_drop_reg;

    // checks
    logic [CNT_W:0] total_tasks;
    assign total_tasks = (CNT_W+1)'(run_stat.fill) + (CNT_W+1)'(wait_stat.fill);

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        run_stat.fill <= count_t'(QUEUE_DEPTH) && wait_stat.fill <= count_t'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_admit_grows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func == FUNC_ADMIT && !run_stat.full
        |=> run_stat.fill == count_t'($past(run_stat.fill) + count_t'(1)))
        else $error("admit did not grow run queue");

    a_tick_conserves: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |=> total_tasks == $past(total_tasks))
        else $error("task lost or duplicated during tick");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid_reg && state_reg != ST_IDLE))
        else $error("work started while a result is pending");

endmodule
